/* src/nfsd_pkg.sv */
// Shared constants, types and the nibble helper function for the nibble frame status decoder.
`timescale 1ns / 1ps

package nfsd_pkg;

  // Frame geometry: all but the last byte are held in the cell chain.
  localparam int FRAME_LEN = 16;
  localparam int STORE_LEN = FRAME_LEN - 1;
  localparam int POS_W = $clog2(FRAME_LEN);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  // Marker and offset codes of the byte stream.
  localparam logic [7:0] SOF_CHAR = 8'h3C;
  localparam logic [7:0] EOF_CHAR = 8'h3E;
  localparam logic [7:0] NIB_OFFSET = 8'h41;

  // Byte offsets of the fields inside a frame.
  localparam int ENC_A_FIRST = 1;
  localparam int ENC_B_FIRST = 5;
  localparam int ENC_C_FIRST = 9;
  localparam int STATUS_BYTE = 13;

  typedef logic [7:0] byte_t;
  typedef byte_t [STORE_LEN-1:0] frame_store_t;

  // Decoded contents of one frame.
  typedef struct packed {
    logic good;
    logic signed [15:0] enc_a;
    logic signed [15:0] enc_b;
    logic signed [15:0] enc_c;
    logic [2:0] homing;
    logic [3:0] grip;
  } frame_status_t;

  // One nibble from one character of the stream.
  function automatic logic [3:0] nib(input byte_t b);
    byte_t diff;
    diff = b - NIB_OFFSET;
    return diff[3:0];
  endfunction

endpackage

/* src/nibble_frame_status_decoder.sv */
// Top level of the nibble frame status decoder: cell chain, frame counter and output register.
`timescale 1ns / 1ps

// The decoder takes one byte per clock cycle while byte_stall is low and groups
// the stream into aligned 16-byte frames starting at reset; it never
// resynchronizes. The first 15 bytes of a frame move through a chain of 15 byte
// cells, and the 16th byte completes the frame: the check and decode happen in
// that cycle and the result appears in the output register on the next cycle.
// The output register is the only buffer, and byte_stall is raised only while a
// result is held there with frame_stall high. A malformed frame (byte 0 not '<'
// or byte 15 not '>') gives a result with frame_good low, all decoded fields
// zero and the good-frame total unchanged.
module nibble_frame_status_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         rx_byte,
  output logic               frame_valid,
  input  logic               frame_stall,
  output logic               frame_good,
  output logic signed [15:0] encoder_a,
  output logic signed [15:0] encoder_b,
  output logic signed [15:0] encoder_c,
  output logic [2:0]         homing_bits,
  output logic [3:0]         grip_bits,
  output logic [15:0]        good_frame_total
);
  import nfsd_pkg::*;

  logic [POS_W-1:0] byte_pos;
  logic [15:0]      good_count;
  logic [15:0]      good_count_next;
  logic             byte_xfer;
  logic             frame_end;
  logic             shift_en;
  byte_t            chain [STORE_LEN+1];
  frame_store_t     frame_bytes;
  frame_status_t    status;

  // Input is held off only while a finished result waits on a stalled output.
  assign byte_stall = frame_valid && frame_stall;
  assign byte_xfer = byte_valid && !byte_stall;
  assign frame_end = byte_xfer && (byte_pos == LAST_POS);
  assign shift_en = byte_xfer && (byte_pos != LAST_POS);

  // Chain of byte cells; cell k holds frame byte STORE_LEN-1-k once filled.
  assign chain[0] = rx_byte;
  for (genvar k = 0; k < STORE_LEN; k++) begin : g_cell
    nfsd_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     (chain[k]),
      .d_out    (chain[k+1])
    );
    assign frame_bytes[STORE_LEN-1-k] = chain[k+1];
  end

  nfsd_decode u_decode (
    .frame_bytes (frame_bytes),
    .last_byte   (rx_byte),
    .status      (status)
  );

  // Position in the frame; wraps naturally after the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= '0;
    end else if (byte_xfer) begin
      byte_pos <= byte_pos + 1'b1;
    end
  end

  // Good-frame count, advanced only by good frames.
  assign good_count_next = (frame_end && status.good) ? good_count + 16'd1 : good_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      good_count <= '0;
    end else begin
      good_count <= good_count_next;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame_end) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  // Output payload, loaded at the end of each frame.
  always_ff @(posedge clk) begin
    if (frame_end) begin
      frame_good <= status.good;
      encoder_a <= status.enc_a;
      encoder_b <= status.enc_b;
      encoder_c <= status.enc_c;
      homing_bits <= status.homing;
      grip_bits <= status.grip;
      good_frame_total <= good_count_next;
    end
  end

  // The last byte of a frame always produces a result on the next cycle.
  assert property (@(posedge clk) disable iff (rst) frame_end |=> frame_valid)
    else $error("frame end did not produce a result");

  // A malformed frame carries zeroed decode fields.
  assert property (@(posedge clk) disable iff (rst)
    (frame_valid && !frame_good) |-> (encoder_a == 16'sd0 && encoder_b == 16'sd0 &&
      encoder_c == 16'sd0 && homing_bits == 3'd0 && grip_bits == 4'd0))
    else $error("malformed frame with nonzero fields");

  // Bytes inside a frame never move the good-frame count.
  assert property (@(posedge clk) disable iff (rst) shift_en |=> $stable(good_count))
    else $error("good count changed inside a frame");

  // The reported total matches the running count right after loading.
  assert property (@(posedge clk) disable iff (rst)
    frame_end |=> (good_frame_total == good_count))
    else $error("reported total differs from good count");

endmodule

/* src/nfsd_cell.sv */
// One byte cell of the frame chain: holds a byte and hands it on when the chain shifts.
`timescale 1ns / 1ps

module nfsd_cell (
  input  logic           clk,
  input  logic           shift_en,
  input  nfsd_pkg::byte_t d_in,
  output nfsd_pkg::byte_t d_out
);
  import nfsd_pkg::*;

  byte_t held;

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= d_in;
    end
  end

  assign d_out = held;

endmodule

/* src/nfsd_decode.sv */
// Frame check and field decode for a complete frame.
`timescale 1ns / 1ps

module nfsd_decode (
  input  nfsd_pkg::frame_store_t  frame_bytes,
  input  nfsd_pkg::byte_t         last_byte,
  output nfsd_pkg::frame_status_t status
);
  import nfsd_pkg::*;

  logic  good;
  byte_t st;

  // A frame is good when both markers sit in place.
  assign good = (frame_bytes[0] == SOF_CHAR) && (last_byte == EOF_CHAR);
  assign st = frame_bytes[STATUS_BYTE] - NIB_OFFSET;

  // Words are built least significant nibble first; a bad frame reads as zero.
  always_comb begin
    status.good = good;
    status.enc_a = '0;
    status.enc_b = '0;
    status.enc_c = '0;
    status.homing = '0;
    status.grip = '0;
    if (good) begin
      status.enc_a = {nib(frame_bytes[ENC_A_FIRST+3]), nib(frame_bytes[ENC_A_FIRST+2]),
                      nib(frame_bytes[ENC_A_FIRST+1]), nib(frame_bytes[ENC_A_FIRST])};
      status.enc_b = {nib(frame_bytes[ENC_B_FIRST+3]), nib(frame_bytes[ENC_B_FIRST+2]),
                      nib(frame_bytes[ENC_B_FIRST+1]), nib(frame_bytes[ENC_B_FIRST])};
      status.enc_c = {nib(frame_bytes[ENC_C_FIRST+3]), nib(frame_bytes[ENC_C_FIRST+2]),
                      nib(frame_bytes[ENC_C_FIRST+1]), nib(frame_bytes[ENC_C_FIRST])};
      status.homing = st[6:4];
      status.grip = st[3:0];
    end
  end

endmodule

/* test/nibble_frame_status_decoder_test.sv */
// Self-checking testbench for the nibble frame status decoder.
`timescale 1ns / 1ps

module nibble_frame_status_decoder_test;
  import nfsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD = 300;

  // One decoded frame as it should leave the block.
  typedef struct packed {
    logic        good;
    logic [15:0] enc_a;
    logic [15:0] enc_b;
    logic [15:0] enc_c;
    logic [2:0]  homing;
    logic [3:0]  grip;
    logic [15:0] total;
  } frame_result_t;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;
  typedef enum int {KIND_GOOD, KIND_BROKEN, KIND_NOISE} frame_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic frame_stall = 1'b0;
  logic byte_stall;
  logic frame_valid;
  logic frame_good;
  logic signed [15:0] encoder_a;
  logic signed [15:0] encoder_b;
  logic signed [15:0] encoder_c;
  logic [2:0] homing_bits;
  logic [3:0] grip_bits;
  logic [15:0] good_frame_total;

  // Predictor state: stored frame bytes, position within the frame, good-frame count.
  byte_t held_bytes [STORE_LEN];
  logic [POS_W-1:0] next_pos = '0;
  logic [15:0] good_total = '0;
  frame_result_t expected_frames[$];

  int error_count = 0;
  int max_byte_gap = 3;
  int max_result_wait = 3;
  int long_hold_cycles = 0;
  int idle_cycles = 0;

  nibble_frame_status_decoder dut (
    .clk              (clk),
    .rst              (rst),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .rx_byte          (rx_byte),
    .frame_valid      (frame_valid),
    .frame_stall      (frame_stall),
    .frame_good       (frame_good),
    .encoder_a        (encoder_a),
    .encoder_b        (encoder_b),
    .encoder_c        (encoder_c),
    .homing_bits      (homing_bits),
    .grip_bits        (grip_bits),
    .good_frame_total (good_frame_total)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The offset 0x41 has a low digit of 1, so a nibble is the low digit minus one.
  function automatic logic [3:0] char_nibble(input logic [7:0] c);
    return c[3:0] - 4'd1;
  endfunction

  // Four stored characters, least significant nibble first.
  function automatic logic [15:0] stored_word(input int first);
    return {char_nibble(held_bytes[first + 3]), char_nibble(held_bytes[first + 2]),
            char_nibble(held_bytes[first + 1]), char_nibble(held_bytes[first])};
  endfunction

  // Advance the predictor by one byte; the last byte of a frame queues a result.
  task automatic predict_byte(input logic [7:0] b);
    frame_result_t r;
    logic [7:0] st;
    if (next_pos != LAST_POS) begin
      held_bytes[next_pos] = b;
      next_pos = next_pos + 1'b1;
    end else begin
      next_pos = '0;
      r = '0;
      if (held_bytes[0] == SOF_CHAR && b == EOF_CHAR) begin
        good_total = good_total + 16'd1;
        st = held_bytes[STATUS_BYTE] - NIB_OFFSET;
        r.good = 1'b1;
        r.enc_a = stored_word(ENC_A_FIRST);
        r.enc_b = stored_word(ENC_B_FIRST);
        r.enc_c = stored_word(ENC_C_FIRST);
        r.homing = st[6:4];
        r.grip = st[3:0];
      end
      r.total = good_total;
      expected_frames.push_back(r);
    end
  endtask

  // Offer one byte after a random gap and hold it until the transfer happens.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, max_byte_gap);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (byte_stall !== 1'b0);
    predict_byte(b);
  endtask

  task automatic send_frame(input frame_t f);
    for (int i = 0; i < FRAME_LEN; i++) send_byte(f[i]);
  endtask

  // Build a frame from its markers, three encoder values and the status byte.
  function automatic frame_t encode_frame(input logic [7:0] first, input logic [15:0] a,
                                          input logic [15:0] b, input logic [15:0] c,
                                          input logic [7:0] status, input logic [7:0] last);
    frame_t f;
    f = '0;
    f[0] = first;
    for (int k = 0; k < 4; k++) begin
      f[ENC_A_FIRST + k] = NIB_OFFSET + 8'(a[4*k +: 4]);
      f[ENC_B_FIRST + k] = NIB_OFFSET + 8'(b[4*k +: 4]);
      f[ENC_C_FIRST + k] = NIB_OFFSET + 8'(c[4*k +: 4]);
    end
    f[STATUS_BYTE] = status;
    // The spare byte before the end marker carries nothing.
    f[FRAME_LEN-2] = 8'h5A;
    f[FRAME_LEN-1] = last;
    return f;
  endfunction

  // Random frame contents; broken frames flip one bit of one marker.
  function automatic frame_t random_frame(input frame_kind_t kind);
    frame_t f;
    for (int i = 0; i < FRAME_LEN; i++) f[i] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0)
      f[$urandom_range(1, FRAME_LEN - 2)] = $urandom_range(0, 1) ? SOF_CHAR : EOF_CHAR;
    case (kind)
      KIND_GOOD: begin
        f[0] = SOF_CHAR;
        f[FRAME_LEN-1] = EOF_CHAR;
      end
      KIND_BROKEN: begin
        f[0] = SOF_CHAR;
        f[FRAME_LEN-1] = EOF_CHAR;
        if ($urandom_range(0, 1))
          f[0] = SOF_CHAR ^ 8'(1 << $urandom_range(0, 7));
        else
          f[FRAME_LEN-1] = EOF_CHAR ^ 8'(1 << $urandom_range(0, 7));
      end
      default: begin
      end
    endcase
    return f;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
    if (got_v !== want_v) begin
      error_count++;
      $display("%0t: %s mismatch: expected 0x%h, actual 0x%h", $time, name, want_v, got_v);
    end
  endtask

  // Compare one result transfer with the oldest expected frame.
  task automatic check_result();
    frame_result_t want;
    if (expected_frames.size() == 0) begin
      error_count++;
      $display("%0t: frame result with none expected: expected nothing, actual total 0x%h",
               $time, good_frame_total);
      return;
    end
    want = expected_frames.pop_front();
    compare_field("frame_good", 16'(want.good), 16'(frame_good));
    compare_field("encoder_a", want.enc_a, encoder_a);
    compare_field("encoder_b", want.enc_b, encoder_b);
    compare_field("encoder_c", want.enc_c, encoder_c);
    compare_field("homing_bits", 16'(want.homing), 16'(homing_bits));
    compare_field("grip_bits", 16'(want.grip), 16'(grip_bits));
    compare_field("good_frame_total", want.total, good_frame_total);
  endtask

  // Receiver: stall for a drawn number of cycles, then take the next result.
  initial begin : result_receiver
    int wait_cycles;
    wait (rst == 1'b0);
    forever begin
      if (long_hold_cycles > 0) begin
        wait_cycles = long_hold_cycles;
        long_hold_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, max_result_wait);
      end
      if (wait_cycles > 0) begin
        frame_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        frame_stall <= 1'b0;
      end
      do @(posedge clk); while (frame_valid !== 1'b1);
      check_result();
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((byte_valid && !byte_stall) || (frame_valid && !frame_stall))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** nibble_frame_status_decoder: FAILED **");
      $finish;
    end
  end

  // Field extremes, marker handling and malformed frames.
  task automatic test_directed_frames();
    frame_t f;
    max_byte_gap = 3;
    max_result_wait = 3;
    send_frame(encode_frame(SOF_CHAR, 16'h0000, 16'h0000, 16'h0000, NIB_OFFSET, EOF_CHAR));
    // Status byte just below the offset wraps to all ones.
    send_frame(encode_frame(SOF_CHAR, 16'h7FFF, 16'h8000, 16'hFFFF, 8'h40, EOF_CHAR));
    send_frame(encode_frame(SOF_CHAR, 16'h1234, 16'hFEDC, 16'h5A5A, 8'h00, EOF_CHAR));
    // Data bytes at 0x00 and 0xFF.
    f = {8{8'hFF, 8'h00}};
    f[0] = SOF_CHAR;
    f[FRAME_LEN-1] = EOF_CHAR;
    send_frame(f);
    // Marker characters inside the data are plain data.
    f = {FRAME_LEN{EOF_CHAR}};
    f[0] = SOF_CHAR;
    send_frame(f);
    // Malformed frames: bad start, bad end, markers swapped.
    send_frame(encode_frame(8'h3D, 16'h1111, 16'h2222, 16'h3333, 8'h55, EOF_CHAR));
    send_frame(encode_frame(SOF_CHAR, 16'h4444, 16'h5555, 16'h6666, 8'h66, SOF_CHAR));
    send_frame(encode_frame(EOF_CHAR, 16'h7777, 16'h8888, 16'h9999, 8'h77, SOF_CHAR));
    send_frame(encode_frame(SOF_CHAR, 16'hCAFE, 16'h0001, 16'h8001, 8'h41, EOF_CHAR));
  endtask

  // Good frames with no idling on either side.
  task automatic test_back_to_back();
    max_byte_gap = 0;
    max_result_wait = 0;
    repeat (10) send_frame(random_frame(KIND_GOOD));
  endtask

  // Mostly well-formed frames with random content, some broken, some noise.
  task automatic test_random_traffic();
    frame_kind_t kind;
    int pick;
    max_byte_gap = 13;
    max_result_wait = 13;
    repeat (60) begin
      pick = $urandom_range(0, 19);
      if (pick < 14)
        kind = KIND_GOOD;
      else if (pick < 17)
        kind = KIND_BROKEN;
      else
        kind = KIND_NOISE;
      send_frame(random_frame(kind));
    end
  endtask

  // Receiver holds off for a long stretch while bytes keep coming.
  task automatic test_output_pressure();
    max_byte_gap = 0;
    max_result_wait = 2;
    long_hold_cycles = LONG_HOLD;
    repeat (5) send_frame(random_frame(KIND_GOOD));
  endtask

  // Test sequence.
  initial begin : run_tests
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_back_to_back();
    test_random_traffic();
    test_output_pressure();
    byte_valid <= 1'b0;
    wait (expected_frames.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("** nibble_frame_status_decoder: PASSED **");
    else
      $display("** nibble_frame_status_decoder: FAILED **");
    $finish;
  end

endmodule
